>>> hw/rtl/i2csqm_pkg.sv
// shared types and constants of the i2c sequence queue manager
`default_nettype none
package i2csqm_pkg;

  localparam int SEQ_W = 8;
  localparam logic [SEQ_W-1:0] NO_SEQ = 8'hFF;

  // hardware status bits
  localparam int ST_DONE_BIT = 0;
  localparam int ST_NACK_BIT = 5;
  localparam int ST_ARB_BIT  = 6;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_DEINIT = 3'd1,
    CMD_ASYNC  = 3'd2,
    CMD_SYNC   = 3'd3,
    CMD_LISTEN = 3'd4,
    CMD_QUERY  = 3'd5,
    CMD_TICK   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_BUSY   = 2'd1,
    MODE_LISTEN = 2'd2
  } mode_t;

  localparam logic [2:0] RES_OK      = 3'd0;
  localparam logic [2:0] RES_PENDING = 3'd1;
  localparam logic [2:0] RES_QUEUED  = 3'd2;
  localparam logic [2:0] RES_FAILED  = 3'd3;
  localparam logic [2:0] RES_NACK    = 3'd4;

  localparam logic [1:0] DE_NONE   = 2'd0;
  localparam logic [1:0] DE_UNINIT = 2'd1;
  localparam logic [1:0] DE_SEQ    = 2'd2;
  localparam logic [1:0] DE_MODE   = 2'd3;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_NACK = 2'd1;
  localparam logic [1:0] EV_ARB  = 2'd2;

  // configuration register indexes
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_ERROR_DETECT   = 3'd0;
  localparam logic [2:0] REG_TRANSMIT_CH    = 3'd1;
  localparam logic [2:0] REG_LISTEN_CH      = 3'd2;
  localparam logic [2:0] REG_LISTEN_TARGET  = 3'd3;
  localparam logic [2:0] REG_LISTEN_ENABLE  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_WR2  = 2'd2
  } state_t;

  typedef struct packed {
    logic [2:0]       command;
    logic [SEQ_W-1:0] sequence_id;
    logic             channel_id;
    logic [7:0]       hw_status;
  } cmd_word_t;

  typedef struct packed {
    logic             accepted;
    logic [1:0]       dev_error;
    logic [2:0]       sequence_result;
    logic [1:0]       runtime_event;
    logic [SEQ_W-1:0] started_sequence;
    logic [SEQ_W-1:0] finished_sequence;
  } rsp_word_t;

endpackage
`default_nettype wire

>>> hw/rtl/i2csqm_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module i2csqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/i2c_sequence_queue_manager.sv
// top level of the i2c sequence queue manager
//  channel   | direction | handshake            | payload
//  cmd       | in        | cmd_valid, cmd_stall | cmd (cmd_word_t)
//  rsp       | out       | rsp_valid, rsp_stall | rsp (rsp_word_t)
//  apb       | in/out    | psel, penable, ...   | paddr, pwdata, prdata
// a command is accepted with table reads, then executed and written back
// a tick that starts a queued sequence also passes through ST_WR2: the result ram has one write port
// reset clears modes, queues and the result valid bits at once, no clearing pass
// a stalled response word holds the block in execute; the next command is taken
// while the previous response still waits
`default_nettype none
module i2c_sequence_queue_manager #(
  parameter int CHANNELS    = 2,
  parameter int QUEUE_DEPTH = 8,
  parameter int SEQUENCES   = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cmd_valid,
  output logic                                     cmd_stall,
  input  wire i2csqm_pkg::cmd_word_t               cmd,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_stall,
  output i2csqm_pkg::rsp_word_t                    rsp,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [i2csqm_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);
  import i2csqm_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QA_W = $clog2(CHANNELS * QUEUE_DEPTH);
  localparam int RA_W = (SEQUENCES > 1) ? $clog2(SEQUENCES) : 1;

  // configuration
  logic error_detect, transmit_channel, listen_channel;
  logic listen_target_mode, listen_enable;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_detect       <= 1'b1;
      transmit_channel   <= 1'b0;
      listen_channel     <= 1'b1;
      listen_target_mode <= 1'b1;
      listen_enable      <= 1'b1;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_ERROR_DETECT:  error_detect       <= pwdata[0];
        REG_TRANSMIT_CH:   transmit_channel   <= pwdata[0];
        REG_LISTEN_CH:     listen_channel     <= pwdata[0];
        REG_LISTEN_TARGET: listen_target_mode <= pwdata[0];
        REG_LISTEN_ENABLE: listen_enable      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ERROR_DETECT:  prdata = {31'd0, error_detect};
      REG_TRANSMIT_CH:   prdata = {31'd0, transmit_channel};
      REG_LISTEN_CH:     prdata = {31'd0, listen_channel};
      REG_LISTEN_TARGET: prdata = {31'd0, listen_target_mode};
      REG_LISTEN_ENABLE: prdata = {31'd0, listen_enable};
      default:           prdata = 32'd0;
    endcase
  end

  // channel number reduced modulo CHANNELS (only 0 and 1 can arrive)
  function automatic logic [CH_W-1:0] ch_of(input logic b);
    ch_of = (CHANNELS > 1) ? CH_W'(b) : '0;
  endfunction

  function automatic logic [QP_W-1:0] ptr_inc(input logic [QP_W-1:0] p);
    ptr_inc = (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [QA_W-1:0] qaddr(input logic [CH_W-1:0] c,
                                            input logic [QP_W-1:0] p);
    qaddr = QA_W'(QA_W'(c) * QA_W'(QUEUE_DEPTH) + QA_W'(p));
  endfunction

  function automatic logic seq_in_range(input logic [SEQ_W-1:0] s);
    seq_in_range = ({1'b0, s} < (SEQ_W + 1)'(SEQUENCES));
  endfunction

  // control state
  state_t state, state_next;
  logic   initialized, initialized_next;
  mode_t            mode [CHANNELS];
  mode_t            mode_next [CHANNELS];
  logic [SEQ_W-1:0] cur [CHANNELS];
  logic [SEQ_W-1:0] cur_next [CHANNELS];
  logic [QP_W-1:0]  head [CHANNELS];
  logic [QP_W-1:0]  head_next [CHANNELS];
  logic [QP_W-1:0]  tail [CHANNELS];
  logic [QP_W-1:0]  tail_next [CHANNELS];
  logic [QC_W-1:0]  count [CHANNELS];
  logic [QC_W-1:0]  count_next [CHANNELS];
  logic             res_vld [SEQUENCES];
  logic             clear_vld;

  // latched command word
  cmd_word_t        cmd_q;
  logic             rv_q;
  logic [SEQ_W-1:0] nx, nx_next;

  // response register
  rsp_word_t rsp_d;
  logic      rsp_load;
  logic      out_free;

  // memories
  logic             res_we, res_re;
  logic [RA_W-1:0]  res_waddr, res_raddr;
  logic [2:0]       res_wdata, res_rdata;
  logic             q_we, q_re;
  logic [QA_W-1:0]  q_waddr, q_raddr;
  logic [SEQ_W-1:0] q_wdata, q_rdata;

  logic accept;
  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // reads are issued as the word is taken
  assign res_re    = accept;
  assign res_raddr = seq_in_range(cmd.sequence_id) ? RA_W'(cmd.sequence_id) : '0;
  assign q_re      = accept;
  assign q_raddr   = qaddr(ch_of(cmd.channel_id), head[ch_of(cmd.channel_id)]);

  i2csqm_ram #(.WIDTH(3), .DEPTH(SEQUENCES)) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .re    (res_re),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  i2csqm_ram #(.WIDTH(SEQ_W), .DEPTH(CHANNELS * QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      rv_q  <= res_vld[res_raddr];
    end
    nx <= nx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      initialized <= 1'b0;
      rsp_valid   <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        mode[c]  <= MODE_IDLE;
        cur[c]   <= NO_SEQ;
        head[c]  <= '0;
        tail[c]  <= '0;
        count[c] <= '0;
      end
      for (int s = 0; s < SEQUENCES; s++) begin
        res_vld[s] <= 1'b0;
      end
    end else begin
      state       <= state_next;
      initialized <= initialized_next;
      mode        <= mode_next;
      cur         <= cur_next;
      head        <= head_next;
      tail        <= tail_next;
      count       <= count_next;
      if (clear_vld) begin
        for (int s = 0; s < SEQUENCES; s++) begin
          res_vld[s] <= 1'b0;
        end
      end else if (res_we) begin
        res_vld[res_waddr] <= 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_d;
    end
  end

  // execute: decode the latched word against the table reads
  logic [2:0]       res_val;
  logic             seq_ok, cur_ok;
  logic [CH_W-1:0]  tc, lc, tch;
  logic [SEQ_W-1:0] tcur;
  logic [1:0]       seq_err;

  always_comb begin
    res_val  = rv_q ? res_rdata : RES_OK;
    seq_ok   = seq_in_range(cmd_q.sequence_id);
    seq_err  = error_detect ? DE_SEQ : DE_NONE;
    tc       = ch_of(transmit_channel);
    lc       = ch_of(listen_channel);
    tch      = ch_of(cmd_q.channel_id);
    tcur     = cur[tch];
    cur_ok   = seq_in_range(tcur);

    state_next       = state;
    initialized_next = initialized;
    mode_next        = mode;
    cur_next         = cur;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    nx_next          = nx;
    clear_vld        = 1'b0;
    res_we           = 1'b0;
    res_waddr        = RA_W'(cmd_q.sequence_id);
    res_wdata        = RES_PENDING;
    q_we             = 1'b0;
    q_waddr          = qaddr(tc, tail[tc]);
    q_wdata          = cmd_q.sequence_id;
    rsp_load         = 1'b0;
    rsp_d.accepted          = 1'b0;
    rsp_d.dev_error         = DE_NONE;
    rsp_d.sequence_result   = RES_OK;
    rsp_d.runtime_event     = EV_NONE;
    rsp_d.started_sequence  = NO_SEQ;
    rsp_d.finished_sequence = NO_SEQ;

    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
          case (cmd_q.command)
            CMD_INIT: begin
              for (int c = 0; c < CHANNELS; c++) begin
                mode_next[c]  = MODE_IDLE;
                cur_next[c]   = NO_SEQ;
                head_next[c]  = '0;
                tail_next[c]  = '0;
                count_next[c] = '0;
              end
              clear_vld        = 1'b1;
              initialized_next = 1'b1;
              rsp_d.accepted   = 1'b1;
            end
            CMD_DEINIT: begin
              if (error_detect && !initialized) begin
                rsp_d.dev_error = DE_UNINIT;
              end else begin
                initialized_next = 1'b0;
                rsp_d.accepted   = 1'b1;
              end
            end
            CMD_ASYNC: begin
              if (error_detect && !initialized) begin
                rsp_d.dev_error = DE_UNINIT;
              end else if (!seq_ok) begin
                rsp_d.dev_error = seq_err;
              end else if (res_val != RES_PENDING) begin
                if (mode[tc] == MODE_IDLE) begin
                  mode_next[tc]  = MODE_BUSY;
                  cur_next[tc]   = cmd_q.sequence_id;
                  res_we         = 1'b1;
                  rsp_d.accepted = 1'b1;
                end else if (count[tc] < QC_W'(QUEUE_DEPTH)) begin
                  q_we           = 1'b1;
                  tail_next[tc]  = ptr_inc(tail[tc]);
                  count_next[tc] = count[tc] + 1'b1;
                  res_we         = 1'b1;
                  res_wdata      = RES_QUEUED;
                  rsp_d.accepted = 1'b1;
                end
              end
            end
            CMD_SYNC: begin
              if (error_detect && !initialized) begin
                rsp_d.dev_error = DE_UNINIT;
              end else if (!seq_ok) begin
                rsp_d.dev_error = seq_err;
              end else if (mode[tc] == MODE_IDLE) begin
                mode_next[tc]  = MODE_BUSY;
                cur_next[tc]   = cmd_q.sequence_id;
                res_we         = 1'b1;
                rsp_d.accepted = 1'b1;
              end
            end
            CMD_LISTEN: begin
              if (error_detect && !initialized) begin
                rsp_d.dev_error = DE_UNINIT;
              end else if (!seq_ok) begin
                rsp_d.dev_error = seq_err;
              end else if (error_detect && !listen_target_mode) begin
                rsp_d.dev_error = DE_MODE;
              end else if (mode[lc] != MODE_LISTEN) begin
                mode_next[lc]  = MODE_LISTEN;
                cur_next[lc]   = cmd_q.sequence_id;
                res_we         = 1'b1;
                rsp_d.accepted = 1'b1;
              end
            end
            CMD_QUERY: begin
              if (!seq_ok) begin
                rsp_d.dev_error       = seq_err;
                rsp_d.sequence_result = RES_FAILED;
              end else begin
                rsp_d.sequence_result = res_val;
                rsp_d.accepted        = 1'b1;
              end
            end
            CMD_TICK: begin
              if ((CHANNELS > 1) || !cmd_q.channel_id) begin
                rsp_d.accepted = 1'b1;
                res_waddr      = RA_W'(tcur);
                if (mode[tch] == MODE_BUSY) begin
                  if (cmd_q.hw_status[ST_NACK_BIT]) begin
                    rsp_d.runtime_event     = EV_NACK;
                    res_we                  = cur_ok;
                    res_wdata               = RES_NACK;
                    rsp_d.finished_sequence = tcur;
                    mode_next[tch]          = MODE_IDLE;
                  end else if (cmd_q.hw_status[ST_ARB_BIT]) begin
                    rsp_d.runtime_event     = EV_ARB;
                    res_we                  = cur_ok;
                    res_wdata               = RES_FAILED;
                    rsp_d.finished_sequence = tcur;
                    mode_next[tch]          = MODE_IDLE;
                  end else if (cmd_q.hw_status[ST_DONE_BIT]) begin
                    res_we                  = cur_ok;
                    res_wdata               = RES_OK;
                    rsp_d.finished_sequence = tcur;
                    if (count[tch] != '0) begin
                      // next queued sequence; its pending mark goes in a second write
                      head_next[tch]         = ptr_inc(head[tch]);
                      count_next[tch]        = count[tch] - 1'b1;
                      cur_next[tch]          = q_rdata;
                      rsp_d.started_sequence = q_rdata;
                      nx_next                = q_rdata;
                      state_next             = ST_WR2;
                    end else begin
                      mode_next[tch] = MODE_IDLE;
                    end
                  end
                end else if (mode[tch] == MODE_LISTEN) begin
                  if (listen_enable && cmd_q.hw_status[ST_DONE_BIT]) begin
                    res_we                  = cur_ok;
                    res_wdata               = RES_OK;
                    rsp_d.finished_sequence = tcur;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_WR2: begin
        res_we     = seq_in_range(nx);
        res_waddr  = RA_W'(nx);
        res_wdata  = RES_PENDING;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> cmd_stall)
    else $error("command taken while another is in flight");

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> state == ST_EXEC)
    else $error("response loaded outside execute");

  a_started_has_finished: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.started_sequence == NO_SEQ || rsp.finished_sequence != NO_SEQ))
    else $error("sequence started without one finishing");

  a_res_write_range: assert property (@(posedge clk) disable iff (rst)
    res_we |-> ({1'b0, res_waddr} < (RA_W + 1)'(SEQUENCES)))
    else $error("result write outside the table");

endmodule
`default_nettype wire
